@@ src/lmts_pkg.sv @@
package lmts_pkg;

	// field and port widths
	localparam int CYCLES_W = 8;
	localparam int TICK_W   = 10;
	localparam int LINE_W   = 8;
	localparam int MODE_W   = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// mode durations in ticks
	localparam logic [TICK_W-1:0] TICKS_OAM    = TICK_W'(80);
	localparam logic [TICK_W-1:0] TICKS_XFER   = TICK_W'(172);
	localparam logic [TICK_W-1:0] TICKS_HBLANK = TICK_W'(204);
	localparam logic [TICK_W-1:0] TICKS_LINE   = TICK_W'(456);

	// scanline landmarks
	localparam logic [LINE_W-1:0] FIRST_VBLANK = LINE_W'(144);
	localparam logic [LINE_W-1:0] LAST_LINE    = LINE_W'(153);

	// lcd modes as reported on the mode output
	typedef enum logic [MODE_W-1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	// configuration register index (byte address / 4)
	typedef enum logic [1:0] {
		REG_HBLANK_IRQ_EN = 2'd0,
		REG_VBLANK_IRQ_EN = 2'd1,
		REG_OAM_IRQ_EN    = 2'd2
	} cfg_reg_t;

endpackage

@@ src/lcd_mode_timing_sequencer_core.sv @@
// an accepted input beat passes through the input register, then the result register;
// one beat per cycle while the result channel is not stalled by out_ready
// the tick/mode/line state updates as each item leaves the input register,
// so the next item sees it with no stall
// reset: asynchronous, active low; mode goes to oam search, ticks and line to zero,
// interrupt enables cleared, both pipeline stages empty
module lcd_mode_timing_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmts_pkg::ADDR_W-1:0]   paddr,
	input  logic [lmts_pkg::DATA_W-1:0]   pwdata,
	output logic [lmts_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lmts_pkg::CYCLES_W-1:0] cycles,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lmts_pkg::MODE_W-1:0]   mode,
	output logic [lmts_pkg::LINE_W-1:0]   line,
	output logic                          vblank_irq,
	output logic                          stat_irq,
	output logic                          render_line,
	output logic                          frame_done
);
	import lmts_pkg::*;

	logic                hblank_irq_en_q;
	logic                vblank_irq_en_q;
	logic                oam_irq_en_q;

	logic                valid_s1;
	logic [CYCLES_W-1:0] cycles_s1;
	logic                advance;

	lcd_mode_t           mode_q;
	lcd_mode_t           mode_n;
	logic [TICK_W-1:0]   tick_q;
	logic [TICK_W-1:0]   tick_n;
	logic [LINE_W-1:0]   line_q;
	logic [LINE_W-1:0]   line_n;

	logic [TICK_W-1:0]   tick_sum;
	logic [LINE_W-1:0]   line_inc;
	logic                hit;
	logic                vbl_n;
	logic                stat_n;
	logic                render_n;

	logic                out_valid_q;
	lcd_mode_t           out_mode_q;
	logic [LINE_W-1:0]   out_line_q;
	logic                out_vbl_q;
	logic                out_stat_q;
	logic                out_render_q;
	logic                out_frame_q;

	// configuration writes and reads
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hblank_irq_en_q <= 1'b0;
			vblank_irq_en_q <= 1'b0;
			oam_irq_en_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (cfg_reg_t'(paddr[3:2]))
				REG_HBLANK_IRQ_EN: hblank_irq_en_q <= pwdata[0];
				REG_VBLANK_IRQ_EN: vblank_irq_en_q <= pwdata[0];
				REG_OAM_IRQ_EN:    oam_irq_en_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[3:2]))
			REG_HBLANK_IRQ_EN: prdata = {{(DATA_W-1){1'b0}}, hblank_irq_en_q};
			REG_VBLANK_IRQ_EN: prdata = {{(DATA_W-1){1'b0}}, vblank_irq_en_q};
			REG_OAM_IRQ_EN:    prdata = {{(DATA_W-1){1'b0}}, oam_irq_en_q};
			default:           prdata = '0;
		endcase
	end

	// handshake: stage 1 moves on whenever the result register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cycles_s1 <= cycles;
		end
	end

	// tick sum and threshold compare for the current mode
	assign tick_sum = tick_q + TICK_W'(cycles_s1);
	assign line_inc = line_q + LINE_W'(1);

	always_comb begin
		case (mode_q)
			MODE_HBLANK: hit = (tick_sum >= TICKS_HBLANK);
			MODE_VBLANK: hit = (tick_sum >= TICKS_LINE);
			MODE_OAM:    hit = (tick_sum >= TICKS_OAM);
			MODE_XFER:   hit = (tick_sum >= TICKS_XFER);
			default:     hit = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		mode_n = mode_q;
		line_n = line_q;
		tick_n = hit ? '0 : tick_sum;
		if (hit) begin
			case (mode_q)
				MODE_HBLANK: begin
					line_n = line_inc;
					mode_n = (line_inc >= FIRST_VBLANK) ? MODE_VBLANK : MODE_OAM;
				end
				MODE_VBLANK: begin
					if (line_inc > LAST_LINE) begin
						line_n = '0;
						mode_n = MODE_OAM;
					end else begin
						line_n = line_inc;
					end
				end
				MODE_OAM:  mode_n = MODE_XFER;
				MODE_XFER: mode_n = MODE_HBLANK;
				default:   mode_n = mode_q;
			endcase
		end
	end

	// event pulses
	always_comb begin
		vbl_n    = 1'b0;
		stat_n   = 1'b0;
		render_n = 1'b0;
		if (hit) begin
			case (mode_q)
				MODE_HBLANK: begin
					vbl_n  = (line_inc >= FIRST_VBLANK);
					stat_n = vbl_n ? vblank_irq_en_q : oam_irq_en_q;
				end
				MODE_VBLANK: stat_n = (line_inc > LAST_LINE) && oam_irq_en_q;
				MODE_XFER: begin
					stat_n   = hblank_irq_en_q;
					render_n = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OAM;
			tick_q <= '0;
			line_q <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			tick_q <= tick_n;
			line_q <= line_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_mode_q   <= mode_n;
			out_line_q   <= line_n;
			out_vbl_q    <= vbl_n;
			out_stat_q   <= stat_n;
			out_render_q <= render_n;
			out_frame_q  <= vbl_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign mode        = out_mode_q;
	assign line        = out_line_q;
	assign vblank_irq  = out_vbl_q;
	assign stat_irq    = out_stat_q;
	assign render_line = out_render_q;
	assign frame_done  = out_frame_q;

`ifndef SYNTHESIS
	// tick counter never rests at or beyond a full line
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TICKS_LINE)
		else $error("tick counter out of range");

	// line counter stays within the frame
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LAST_LINE)
		else $error("line counter past last line");

	// frame done only on entry to vblank at the first vblank line
	a_frame_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frame_q |->
			out_vbl_q && out_mode_q == MODE_VBLANK && out_line_q == FIRST_VBLANK)
		else $error("frame done without vblank entry");

	// render pulse only on entry to hblank
	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_render_q |-> out_mode_q == MODE_HBLANK)
		else $error("render pulse outside hblank entry");

	// state only moves when an item leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q) && $stable(tick_q) && $stable(line_q))
		else $error("timing state changed without an item");
`endif

endmodule
